// ----- src/julian_day_to_calendar_date_macros.svh -----
// Assertion helpers shared by the date converter pipeline.
// Each helper samples on i_clk and is switched off while i_rst_n is low.
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_MACROS_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JDCD_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jdcd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define JDCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jdcd: next-cycle check failed");

`endif

// ----- src/jdcd_pkg.sv -----
package jdcd_pkg;

    localparam logic [31:0] LastJulianDay  = 32'd2299160;
    localparam logic [31:0] GregOffset     = 32'd2159351;
    localparam logic [17:0] GregCycleDays  = 18'd146097;
    localparam logic [10:0] JulCycleDays   = 11'd1461;

    // Reciprocals for division by the cycle lengths. The Gregorian one is
    // applied to the day count shifted right by eight bits.
    localparam logic [22:0] GregRecip  = 23'((64'd1 << 40) / 64'd146097);
    localparam logic [21:0] JulRecip   = 22'((64'd1 << 32) / 64'd1461);
    localparam logic [17:0] GroupRecip = 18'((64'd1 << 28) / 64'd1461 + 64'd1);

    localparam logic [24:0] GregBaseYear    = 25'd1200;
    localparam logic [24:0] JulBaseYearMag  = 25'd4712;
    localparam logic [24:0] GregCycleYears  = 25'd400;
    localparam logic [24:0] JulCycleYears   = 25'd4;
    localparam logic [24:0] CenturyYears    = 25'd100;

    localparam logic [17:0] FirstCenturyDays = 18'd36525;
    localparam logic [17:0] CenturyDays      = 18'd36524;
    localparam logic [17:0] Century2Start    = 18'd73048;
    localparam logic [17:0] Century3Start    = 18'd109572;
    localparam logic [4:0]  GroupsPerCentury = 5'd25;
    localparam logic [10:0] CommonYearDays   = 11'd365;

    localparam int          MonthsPerYear  = 12;
    localparam logic [3:0]  MarchIndex     = 4'd2;
    localparam logic [3:0]  FebruaryNumber = 4'd2;

    localparam logic [8:0] MonthStart [MonthsPerYear] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic        greg;
        logic [14:0] quot;
        logic [17:0] offset;
    } t_div_result;

    typedef struct packed {
        logic [8:0]  day_of_year;
        logic        leap;
        logic [24:0] year;
    } t_day_info;

    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] month_idx);
        logic [8:0] start;
        start = MonthStart[month_idx];
        if (leap && month_idx >= MarchIndex) begin
            start = start + 9'd1;
        end
        return start;
    endfunction

endpackage

// ----- src/jdcd_divider.sv -----
`include "julian_day_to_calendar_date_macros.svh"

module jdcd_divider (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [31:0]           i_day_number,
    output logic                  o_ready,
    output logic                  o_valid,
    output jdcd_pkg::t_div_result o_result,
    input  logic                  i_ready
);
    import jdcd_pkg::*;

    logic [4:0]  r_valid;
    logic [4:0]  stage_en;

    logic        r_s1_greg;
    logic [31:0] r_s1_num;
    logic        r_s2_greg;
    logic [31:0] r_s2_num;
    logic [14:0] r_s2_quot;
    logic        r_s3_greg;
    logic [31:0] r_s3_num;
    logic [31:0] r_s3_prod;
    logic [14:0] r_s3_quot;
    logic        r_s4_greg;
    logic [18:0] r_s4_rem;
    logic [14:0] r_s4_quot;
    t_div_result r_s5;

    logic        n_s1_greg;
    logic [31:0] n_s1_num;
    logic [23:0] mul_a;
    logic [22:0] mul_b;
    logic [46:0] mul_p;
    logic [17:0] s3_divisor;
    logic [32:0] s3_prod;
    logic [31:0] s4_diff;
    logic [17:0] s5_divisor;
    logic [18:0] s4_rem_limit;
    logic [17:0] out_divisor;
    t_div_result n_s5;

    assign stage_en[4] = !r_valid[4] || i_ready;
    assign stage_en[3] = !r_valid[3] || stage_en[4];
    assign stage_en[2] = !r_valid[2] || stage_en[3];
    assign stage_en[1] = !r_valid[1] || stage_en[2];
    assign stage_en[0] = !r_valid[0] || stage_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= (stage_en & {r_valid[3:0], i_valid}) | (~stage_en & r_valid);
        end
    end

    // Pick the calendar and the dividend.
    always_comb begin
        n_s1_greg = i_day_number > LastJulianDay;
        n_s1_num  = n_s1_greg ? (i_day_number - GregOffset) : {10'd0, i_day_number[21:0]};
    end

    // Quotient estimate by reciprocal; it is low by at most one.
    always_comb begin
        mul_a = r_s1_greg ? r_s1_num[31:8] : {2'd0, r_s1_num[21:0]};
        mul_b = r_s1_greg ? GregRecip : {1'b0, JulRecip};
        mul_p = 47'(mul_a) * 47'(mul_b);
    end

    always_comb begin
        s3_divisor = r_s2_greg ? GregCycleDays : {7'd0, JulCycleDays};
        s3_prod    = 33'(r_s2_quot) * 33'(s3_divisor);
        s4_diff    = r_s3_num - r_s3_prod;
    end

    always_comb begin
        s5_divisor   = r_s4_greg ? GregCycleDays : {7'd0, JulCycleDays};
        s4_rem_limit = {s5_divisor, 1'b0};
        n_s5.greg    = r_s4_greg;
        if (r_s4_rem >= {1'b0, s5_divisor}) begin
            n_s5.offset = 18'(r_s4_rem - {1'b0, s5_divisor});
            n_s5.quot   = r_s4_quot + 15'd1;
        end else begin
            n_s5.offset = r_s4_rem[17:0];
            n_s5.quot   = r_s4_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_s1_greg <= n_s1_greg;
            r_s1_num  <= n_s1_num;
        end
        if (stage_en[1]) begin
            r_s2_greg <= r_s1_greg;
            r_s2_num  <= r_s1_num;
            r_s2_quot <= mul_p[46:32];
        end
        if (stage_en[2]) begin
            r_s3_greg <= r_s2_greg;
            r_s3_num  <= r_s2_num;
            r_s3_prod <= s3_prod[31:0];
            r_s3_quot <= r_s2_quot;
        end
        if (stage_en[3]) begin
            r_s4_greg <= r_s3_greg;
            r_s4_rem  <= s4_diff[18:0];
            r_s4_quot <= r_s3_quot;
        end
        if (stage_en[4]) begin
            r_s5 <= n_s5;
        end
    end

    assign out_divisor = r_s5.greg ? GregCycleDays : {7'd0, JulCycleDays};

    assign o_ready  = stage_en[0];
    assign o_valid  = r_valid[4];
    assign o_result = r_s5;

    `JDCD_ASSERT_IMPLIES(a_rem_below_twice, r_valid[3], r_s4_rem < s4_rem_limit)
    `JDCD_ASSERT_IMPLIES(a_offset_in_cycle, r_valid[4], r_s5.offset < out_divisor)
    `JDCD_ASSERT_NEXT(a_result_held, r_valid[4] && !i_ready, r_valid[4] && $stable(r_s5))

endmodule

// ----- src/jdcd_cycle_decode.sv -----
`include "julian_day_to_calendar_date_macros.svh"

module jdcd_cycle_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  jdcd_pkg::t_div_result i_result,
    output logic                  o_ready,
    output logic                  o_valid,
    output jdcd_pkg::t_day_info   o_info,
    input  logic                  i_ready
);
    import jdcd_pkg::*;

    logic [3:0]  r_valid;
    logic [3:0]  stage_en;

    logic [1:0]  r_s6_century;
    logic [15:0] r_s6_dc;
    logic [24:0] r_s6_base;
    logic [15:0] r_s7_e;
    logic [4:0]  r_s7_group;
    logic        r_s7_late_century;
    logic [24:0] r_s7_base;
    logic [10:0] r_s8_eg;
    logic        r_s8_leap_grp;
    logic [24:0] r_s8_base;
    t_day_info   r_s9;

    logic [17:0] off_m1;
    logic [1:0]  n_s6_century;
    logic [15:0] n_s6_dc;
    logic [24:0] quot_ext;
    logic [24:0] n_s6_base;
    logic [15:0] n_s7_e;
    logic [33:0] grp_prod;
    logic [24:0] n_s7_base;
    logic [15:0] grp_days;
    logic [15:0] grp_off;
    logic        n_s8_leap_grp;
    logic [10:0] n_s8_eg;
    logic [24:0] n_s8_base;
    logic [10:0] yr1;
    logic [10:0] yr2;
    logic [10:0] yr3;
    logic [1:0]  year_in_grp;
    logic [10:0] year_start;
    t_day_info   n_s9;
    logic [10:0] doy_limit;

    assign stage_en[3] = !r_valid[3] || i_ready;
    assign stage_en[2] = !r_valid[2] || stage_en[3];
    assign stage_en[1] = !r_valid[1] || stage_en[2];
    assign stage_en[0] = !r_valid[0] || stage_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= (stage_en & {r_valid[2:0], i_valid}) | (~stage_en & r_valid);
        end
    end

    // Century within the 400-year pattern; only the first one has 36525 days.
    always_comb begin
        off_m1 = i_result.offset - 18'd1;
        if (i_result.offset < FirstCenturyDays) begin
            n_s6_century = 2'd0;
            n_s6_dc      = i_result.offset[15:0];
        end else if (off_m1 < Century2Start) begin
            n_s6_century = 2'd1;
            n_s6_dc      = 16'(off_m1 - CenturyDays);
        end else if (off_m1 < Century3Start) begin
            n_s6_century = 2'd2;
            n_s6_dc      = 16'(off_m1 - Century2Start);
        end else begin
            n_s6_century = 2'd3;
            n_s6_dc      = 16'(off_m1 - Century3Start);
        end
        quot_ext  = 25'(i_result.quot);
        n_s6_base = i_result.greg ? (quot_ext * GregCycleYears + GregBaseYear)
                                  : (quot_ext * JulCycleYears - JulBaseYearMag);
    end

    // A later century opens with a short four-year group; one extra day aligns it.
    always_comb begin
        n_s7_e    = r_s6_dc + {15'd0, r_s6_century != 2'd0};
        grp_prod  = 34'(n_s7_e) * 34'(GroupRecip);
        n_s7_base = r_s6_base + 25'(r_s6_century) * CenturyYears;
    end

    always_comb begin
        grp_days      = 16'(r_s7_group) * 16'(JulCycleDays);
        grp_off       = r_s7_e - grp_days;
        n_s8_leap_grp = !(r_s7_late_century && r_s7_group == 5'd0);
        n_s8_eg       = n_s8_leap_grp ? grp_off[10:0] : grp_off[10:0] - 11'd1;
        n_s8_base     = r_s7_base + {18'd0, r_s7_group, 2'b00};
    end

    always_comb begin
        yr1 = CommonYearDays + {10'd0, r_s8_leap_grp};
        yr2 = yr1 + CommonYearDays;
        yr3 = yr2 + CommonYearDays;
        if (r_s8_eg < yr1) begin
            year_in_grp = 2'd0;
            year_start  = 11'd0;
        end else if (r_s8_eg < yr2) begin
            year_in_grp = 2'd1;
            year_start  = yr1;
        end else if (r_s8_eg < yr3) begin
            year_in_grp = 2'd2;
            year_start  = yr2;
        end else begin
            year_in_grp = 2'd3;
            year_start  = yr3;
        end
        n_s9.day_of_year = 9'(r_s8_eg - year_start);
        n_s9.leap        = r_s8_leap_grp && year_in_grp == 2'd0;
        n_s9.year        = r_s8_base + {23'd0, year_in_grp};
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_s6_century <= n_s6_century;
            r_s6_dc      <= n_s6_dc;
            r_s6_base    <= n_s6_base;
        end
        if (stage_en[1]) begin
            r_s7_e            <= n_s7_e;
            r_s7_group        <= grp_prod[32:28];
            r_s7_late_century <= r_s6_century != 2'd0;
            r_s7_base         <= n_s7_base;
        end
        if (stage_en[2]) begin
            r_s8_eg       <= n_s8_eg;
            r_s8_leap_grp <= n_s8_leap_grp;
            r_s8_base     <= n_s8_base;
        end
        if (stage_en[3]) begin
            r_s9 <= n_s9;
        end
    end

    assign doy_limit = CommonYearDays + {10'd0, r_s9.leap};

    assign o_ready = stage_en[0];
    assign o_valid = r_valid[3];
    assign o_info  = r_s9;

    `JDCD_ASSERT_IMPLIES(a_century_day_range, r_valid[0], r_s6_dc < FirstCenturyDays)
    `JDCD_ASSERT_IMPLIES(a_group_range, r_valid[1], r_s7_group < GroupsPerCentury)
    `JDCD_ASSERT_IMPLIES(a_day_of_year_range, r_valid[3], r_s9.day_of_year < doy_limit)

endmodule

// ----- src/jdcd_month_decode.sv -----
`include "julian_day_to_calendar_date_macros.svh"

module jdcd_month_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  jdcd_pkg::t_day_info i_info,
    output logic                o_ready,
    output logic                o_valid,
    output logic [4:0]          o_day_of_month,
    output logic [3:0]          o_month_number,
    output logic [23:0]         o_year_number,
    output logic                o_before_christ,
    input  logic                i_ready
);
    import jdcd_pkg::*;

    logic        r_valid;
    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [23:0] r_year;
    logic        r_bc;

    logic        stage_en;
    logic [3:0]  month_idx;
    logic [8:0]  day_in_month;
    logic [4:0]  n_day;
    logic [3:0]  n_month;
    logic [23:0] n_year;
    logic        n_bc;

    assign stage_en = !r_valid || i_ready;

    always_comb begin
        month_idx = 4'd0;
        for (int k = 1; k < MonthsPerYear; k++) begin
            if (i_info.day_of_year >= month_start(i_info.leap, 4'(k))) begin
                month_idx = 4'(k);
            end
        end
        day_in_month = i_info.day_of_year - month_start(i_info.leap, month_idx);
        n_day        = 5'(day_in_month) + 5'd1;
        n_month      = month_idx + 4'd1;
        if ($signed(i_info.year) > 25'sd0) begin
            n_year = i_info.year[23:0];
            n_bc   = 1'b0;
        end else begin
            n_year = 24'(25'd1 - i_info.year);
            n_bc   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (stage_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en) begin
            r_day   <= n_day;
            r_month <= n_month;
            r_year  <= n_year;
            r_bc    <= n_bc;
        end
    end

    assign o_ready         = stage_en;
    assign o_valid         = r_valid;
    assign o_day_of_month  = r_day;
    assign o_month_number  = r_month;
    assign o_year_number   = r_year;
    assign o_before_christ = r_bc;

    `JDCD_ASSERT_IMPLIES(a_month_range, r_valid, r_month >= 4'd1 && r_month <= 4'd12)
    `JDCD_ASSERT_IMPLIES(a_day_range, r_valid, r_day >= 5'd1 && r_day <= 5'd31)
    `JDCD_ASSERT_IMPLIES(a_february_length, r_valid && r_month == FebruaryNumber, r_day <= 5'd29)
    `JDCD_ASSERT_IMPLIES(a_year_nonzero, r_valid, r_year != 24'd0)

endmodule

// ----- src/julian_day_to_calendar_date.sv -----
// Converts a Julian day number (day 0 is 1 January 4713 BC) into a calendar
// date: day of month, month, year and a BC flag. Days up to 4 October 1582
// use the Julian calendar; later days use the Gregorian calendar.
// The input channel is i_valid / o_stall with i_day_number; an item is taken
// at a rising edge where i_valid is high and o_stall is low. The output
// channel is o_valid / i_stall with the four date fields; a result is taken
// at a rising edge where o_valid is high and i_stall is low.
// The pipeline has ten register stages; while the output is not stalled, one
// item can be taken in every cycle. The depth is set by the reciprocal divide
// of the cycle split, its remainder fix-up, and the year, group and month
// decode steps.
// Reset is synchronous and active low; it empties the pipeline and nothing
// else is kept between items. When the receiver stalls, the output holds its
// result unchanged, earlier stages keep filling any empty slots, and o_stall
// rises only once the first stage cannot move forward.
module julian_day_to_calendar_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_day_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_number,
    output logic [23:0] o_year_number,
    output logic        o_before_christ
);
    import jdcd_pkg::*;

    logic        div_ready;
    logic        div_valid;
    t_div_result div_result;
    logic        cyc_ready;
    logic        cyc_valid;
    t_day_info   cyc_info;
    logic        mon_ready;

    jdcd_divider u_divider (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_day_number (i_day_number),
        .o_ready      (div_ready),
        .o_valid      (div_valid),
        .o_result     (div_result),
        .i_ready      (cyc_ready)
    );

    jdcd_cycle_decode u_cycle_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (div_valid),
        .i_result (div_result),
        .o_ready  (cyc_ready),
        .o_valid  (cyc_valid),
        .o_info   (cyc_info),
        .i_ready  (mon_ready)
    );

    jdcd_month_decode u_month_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (cyc_valid),
        .i_info          (cyc_info),
        .o_ready         (mon_ready),
        .o_valid         (o_valid),
        .o_day_of_month  (o_day_of_month),
        .o_month_number  (o_month_number),
        .o_year_number   (o_year_number),
        .o_before_christ (o_before_christ),
        .i_ready         (!i_stall)
    );

    assign o_stall = !div_ready;

endmodule
